/* src/bbe_pkg.sv */
// shared types and constants of the edge-aware 3x3 box blur
package bbe_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int OROW_W = $clog2(MAX_HEIGHT);
  localparam int IROW_W = OROW_W + 2;
  localparam int FW_W   = 11;
  localparam int FH_W   = 13;
  localparam int CFG_W  = 13;
  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int Y_W    = 12;
  localparam int RCP_W  = 16;

  localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);

  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [RCP_W-1:0] RECIP3 = RCP_W'(43691);
  localparam logic [RCP_W-1:0] RECIP9 = RCP_W'(58255);
  localparam int SHIFT3 = 17;
  localparam int SHIFT9 = 19;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef enum logic [1:0] {
    DIV_BY_1,
    DIV_BY_3,
    DIV_BY_9
  } div_sel_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_SUM,
    S_DIV
  } bbe_state_t;

  typedef struct packed {
    logic shift;
    logic sum_en;
    logic top_en;
    logic bot_en;
    logic left_en;
    logic right_en;
  } win_ctrl_t;

endpackage

/* src/bbe_line_store.sv */
// two row stores in one synchronous memory, one read and one write port
module bbe_line_store (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [bbe_pkg::COL_W-1:0] rd_addr,
  output bbe_pkg::pixel_t           rd_older,
  output bbe_pkg::pixel_t           rd_newer,
  input  logic                      wr_en,
  input  logic [bbe_pkg::COL_W-1:0] wr_addr,
  input  bbe_pkg::pixel_t           wr_older,
  input  bbe_pkg::pixel_t           wr_newer
);
  import bbe_pkg::*;

  logic [2*PIX_W-1:0] mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_older, wr_newer};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign rd_older = rd_data[2*PIX_W-1:PIX_W];
  assign rd_newer = rd_data[PIX_W-1:0];

endmodule

/* src/bbe_window.sv */
// 3x3 window registers, masked channel sums and pre-shift of the rounded mean
module bbe_window (
  input  logic                             clk,
  input  logic                             rst,
  input  bbe_pkg::win_ctrl_t               ctrl,
  input  bbe_pkg::pixel_t                  top,
  input  bbe_pkg::pixel_t                  mid,
  input  bbe_pkg::pixel_t                  newest,
  output logic [2:0][bbe_pkg::Y_W-1:0]     y,
  output bbe_pkg::div_sel_t                div_sel
);
  import bbe_pkg::*;

  pixel_t              win [3][3];
  logic [2:0]          row_en;
  logic [2:0]          col_en;
  logic [1:0]          rc;
  logic [1:0]          cc;
  logic [3:0]          count;
  logic [1:0]          sh;
  logic [2:0][Y_W-1:0] acc;
  logic [2:0][Y_W:0]   n;
  logic [2:0][Y_W-1:0] y_next;
  div_sel_t            div_sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (ctrl.shift) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= top;
      win[1][2] <= mid;
      win[2][2] <= newest;
    end
  end

  always_comb begin
    row_en = {ctrl.bot_en, 1'b1, ctrl.top_en};
    col_en = {ctrl.right_en, 1'b1, ctrl.left_en};
    rc = {1'b0, ctrl.top_en} + {1'b0, ctrl.bot_en} + 2'd1;
    cc = {1'b0, ctrl.left_en} + {1'b0, ctrl.right_en} + 2'd1;
    count = {2'b00, rc} * {2'b00, cc};
    sh = 2'd1 + {1'b0, rc == 2'd2} + {1'b0, cc == 2'd2};
    for (int ch = 0; ch < 3; ch++) begin
      acc[ch] = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (row_en[r] && col_en[c]) begin
            acc[ch] = acc[ch] + Y_W'(win[r][c][ch*CH_W +: CH_W]);
          end
        end
      end
      n[ch] = {acc[ch], 1'b0} + (Y_W+1)'(count);
      y_next[ch] = Y_W'(n[ch] >> sh);
    end
    case ({1'b0, rc == 2'd3} + {1'b0, cc == 2'd3})
      2'd1:    div_sel_next = DIV_BY_3;
      2'd2:    div_sel_next = DIV_BY_9;
      default: div_sel_next = DIV_BY_1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.sum_en) begin
      y       <= y_next;
      div_sel <= div_sel_next;
    end
  end

endmodule

/* src/bbe_scale.sv */
// divides the pre-shifted sums by one, three or nine with a reciprocal multiply
module bbe_scale (
  input  logic [2:0][bbe_pkg::Y_W-1:0]  y,
  input  bbe_pkg::div_sel_t             div_sel,
  output logic [2:0][bbe_pkg::CH_W-1:0] q
);
  import bbe_pkg::*;

  logic [RCP_W-1:0]          recip;
  logic [2:0][Y_W+RCP_W-1:0] prod;

  always_comb begin
    case (div_sel)
      DIV_BY_9: recip = RECIP9;
      default:  recip = RECIP3;
    endcase
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = {{RCP_W{1'b0}}, y[ch]} * {{Y_W{1'b0}}, recip};
      case (div_sel)
        DIV_BY_3: q[ch] = prod[ch][SHIFT3 +: CH_W];
        DIV_BY_9: q[ch] = prod[ch][SHIFT9 +: CH_W];
        default:  q[ch] = y[ch][CH_W-1:0];
      endcase
    end
  end

endmodule

/* src/box_blur_3x3_edge_aware_unit.sv */
// top level of the edge-aware 3x3 box blur with frame control
// usage:
//   pixels enter in raster order on the in_valid/in_ready channel; action 0
//   pushes a pixel, action 1 is a flush that releases one pending output once
//   the whole frame has been pushed. frame size comes from cfg_write/cfg_index/
//   cfg_data (index 0 width, index 1 height); a write restarts the frame.
//   results leave on out_valid/out_ready; frame_last marks the bottom-right pixel.
// sequence:
//   a transaction that yields a result runs through line store read, window
//   shift, masked sum, reciprocal scale into the output register. one that only
//   advances the window ends after the shift, an ignored one at acceptance.
//   one transaction is in flight at a time; the read, shift, sum and scale
//   steps run in turn and set the pace.
// reset:
//   counters clear, the window clears, size returns to 640x480. the line store
//   is not cleared; unwritten entries are only read for masked neighbors.
// stall:
//   a held result keeps its register; the next transaction may be taken and
//   waits in its scale step until the output register frees.
module box_blur_3x3_edge_aware_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      action,
  input  logic [bbe_pkg::CH_W-1:0]  in_red,
  input  logic [bbe_pkg::CH_W-1:0]  in_green,
  input  logic [bbe_pkg::CH_W-1:0]  in_blue,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bbe_pkg::CH_W-1:0]  out_red,
  output logic [bbe_pkg::CH_W-1:0]  out_green,
  output logic [bbe_pkg::CH_W-1:0]  out_blue,
  output logic                      frame_last,
  input  logic                      cfg_write,
  input  logic                      cfg_index,
  input  logic [bbe_pkg::CFG_W-1:0] cfg_data
);
  import bbe_pkg::*;

  bbe_state_t           state;
  bbe_state_t           state_next;
  logic [FW_W-1:0]      fw;
  logic [FH_W-1:0]      fh;
  logic [FW_W-1:0]      eff_w;
  logic [FH_W-1:0]      eff_h;
  logic [COL_W-1:0]     in_col;
  logic [IROW_W-1:0]    in_row;
  logic [COL_W-1:0]     out_col;
  logic [OROW_W-1:0]    out_row;
  pixel_t               newest;
  logic                 wr_stores;
  logic                 last_sum;
  logic                 accept;
  logic                 all_pushed;
  logic                 act;
  logic                 adv_ready;
  logic                 in_col_wrap;
  logic                 out_col_wrap;
  logic                 out_row_end;
  logic                 last;
  logic                 out_load;
  pixel_t               rd_older;
  pixel_t               rd_newer;
  win_ctrl_t            ctrl;
  logic [2:0][Y_W-1:0]  y;
  div_sel_t             div_sel;
  logic [2:0][CH_W-1:0] q;

  always_comb begin
    eff_w = fw;
    if (fw == '0) begin
      eff_w = FW_W'(1);
    end else if (fw > FW_W'(MAX_WIDTH)) begin
      eff_w = FW_W'(MAX_WIDTH);
    end
    eff_h = fh;
    if (fh == '0) begin
      eff_h = FH_W'(1);
    end else if (fh > FH_W'(MAX_HEIGHT)) begin
      eff_h = FH_W'(MAX_HEIGHT);
    end
  end

  assign accept       = in_valid && in_ready;
  assign all_pushed   = in_row >= IROW_W'(eff_h);
  assign act          = action ? all_pushed : !all_pushed;
  assign adv_ready    = (in_row >= IROW_W'(2)) || (in_row == IROW_W'(1) && in_col != '0);
  assign in_col_wrap  = ({1'b0, in_col} + FW_W'(1)) >= eff_w;
  assign out_col_wrap = ({1'b0, out_col} + FW_W'(1)) >= eff_w;
  assign out_row_end  = ({1'b0, out_row} + FH_W'(1)) >= eff_h;
  assign last         = out_row_end && out_col_wrap;
  assign out_load     = (state == S_DIV) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    ctrl.shift    = 1'b0;
    ctrl.sum_en   = 1'b0;
    ctrl.top_en   = out_row != '0;
    ctrl.bot_en   = !out_row_end;
    ctrl.left_en  = out_col != '0;
    ctrl.right_en = !out_col_wrap;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (accept && act) begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        ctrl.shift = 1'b1;
        state_next = adv_ready ? S_SUM : S_IDLE;
      end
      S_SUM: begin
        ctrl.sum_en = 1'b1;
        state_next  = S_DIV;
      end
      S_DIV: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fw      <= FW_RESET;
      fh      <= FH_RESET;
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  fw <= cfg_data[FW_W-1:0];
        CFG_FRAME_HEIGHT: fh <= cfg_data[FH_W-1:0];
        default: ;
      endcase
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else begin
      if (state == S_SHIFT) begin
        if (in_col_wrap) begin
          in_col <= '0;
          in_row <= in_row + IROW_W'(1);
        end else begin
          in_col <= in_col + COL_W'(1);
        end
      end
      if (state == S_SUM) begin
        if (last) begin
          in_col  <= '0;
          in_row  <= '0;
          out_col <= '0;
          out_row <= '0;
        end else if (out_col_wrap) begin
          out_col <= '0;
          out_row <= out_row + OROW_W'(1);
        end else begin
          out_col <= out_col + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && act) begin
      newest    <= action ? '0 : {in_blue, in_green, in_red};
      wr_stores <= !action;
    end
    if (state == S_SUM) begin
      last_sum <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_red    <= q[0];
      out_green  <= q[1];
      out_blue   <= q[2];
      frame_last <= last_sum;
    end
  end

  bbe_line_store u_line_store (
    .clk      (clk),
    .rd_en    (accept && act),
    .rd_addr  (in_col),
    .rd_older (rd_older),
    .rd_newer (rd_newer),
    .wr_en    ((state == S_SHIFT) && wr_stores),
    .wr_addr  (in_col),
    .wr_older (rd_newer),
    .wr_newer (newest)
  );

  bbe_window u_window (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .top     (rd_older),
    .mid     (rd_newer),
    .newest  (newest),
    .y       (y),
    .div_sel (div_sel)
  );

  bbe_scale u_scale (
    .y       (y),
    .div_sel (div_sel),
    .q       (q)
  );

`ifndef SYNTHESIS
  a_div_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && out_valid && !out_ready) |=> (state == S_DIV))
    else $error("scale step left while output register was full");

  a_out_in_frame: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, out_row} < eff_h) && ({1'b0, out_col} < eff_w))
    else $error("output position outside the frame");

  a_in_col_in_row: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, in_col} < eff_w))
    else $error("input column beyond frame width");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM && last) |=> (in_row == '0 && out_row == '0 && out_col == '0))
    else $error("counters not cleared after the frame's last output");
`endif

endmodule
